// ===== design/quadratic_real_roots_assert.svh =====
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_REAL_ROOTS_ASSERT_SVH
`define QUADRATIC_REAL_ROOTS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QRR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define QRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QRR_ASSERT(label, clk, rst_n, prop)
`define QRR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/qrr_pkg.sv =====
// Shared constants and types for the quadratic root solver.
package qrr_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOREAL = 2'd1;
    localparam logic [1:0] ST_DEGEN  = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    typedef struct packed {
        logic a_neg;
        logic b_neg;
        logic c_neg;
        logic no_real;
        logic degen;
    } qrr_flags_t;

endpackage

// ===== design/qrr_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qrr_sqrt
    import qrr_pkg::*;
#(
    parameter int R  = WORD_BITS_DEF + 1,
    parameter int SB = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [2*R-1:0]   rad,
    input  logic [SB-1:0]    side_in,
    output logic             out_valid,
    output logic [R-1:0]     root,
    output logic [SB-1:0]    side_out
);

    localparam int RW = R + 2;

    logic [R:0]      valid_reg;
    logic [2*R-1:0]  rad_reg  [0:R];
    logic [RW-1:0]   rem_reg  [0:R];
    logic [R-1:0]    root_reg [0:R];
    logic [SB-1:0]   side_reg [0:R];

    logic [2*R-1:0]  rad_next  [1:R];
    logic [RW-1:0]   rem_next  [1:R];
    logic [R-1:0]    root_next [1:R];

    genvar k;
    generate
        for (k = 0; k < R; k++) begin : g_step
            logic [RW-1:0] rem2;
            logic [RW-1:0] trial;
            logic          ge;
            always_comb
            begin
                rem2  = {rem_reg[k][RW-3:0], rad_reg[k][2*R-1 -: 2]};
                trial = {root_reg[k], 2'b01};
                ge    = rem2 >= trial;
                rem_next[k+1]  = ge ? (rem2 - trial) : rem2;
                root_next[k+1] = {root_reg[k][R-2:0], ge};
                rad_next[k+1]  = {rad_reg[k][2*R-3:0], 2'b00};
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[R-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
            for (int i = 1; i <= R; i++)
            begin
                rad_reg[i]  <= rad_next[i];
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[R];
    assign root      = root_reg[R];
    assign side_out  = side_reg[R];

endmodule

// ===== design/qrr_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage.
module qrr_div
    import qrr_pkg::*;
#(
    parameter int NB = WORD_BITS_DEF + 2 + FRAC_BITS_DEF,
    parameter int Q  = WORD_BITS_DEF + 2,
    parameter int SB = 5
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [NB-1:0]  num0,
    input  logic [Q-1:0]   den0,
    input  logic [NB-1:0]  num1,
    input  logic [Q-1:0]   den1,
    input  logic [SB-1:0]  side_in,
    output logic           out_valid,
    output logic [NB-1:0]  quo0,
    output logic [NB-1:0]  quo1,
    output logic [SB-1:0]  side_out
);

    logic [NB:0]    valid_reg;
    logic [NB-1:0]  nq_reg  [0:1][0:NB];
    logic [Q-1:0]   rem_reg [0:1][0:NB];
    logic [Q-1:0]   den_reg [0:1][0:NB];
    logic [SB-1:0]  side_reg [0:NB];

    logic [NB-1:0]  nq_next  [0:1][1:NB];
    logic [Q-1:0]   rem_next [0:1][1:NB];

    genvar ln, k;
    generate
        for (ln = 0; ln < 2; ln++) begin : g_lane
            for (k = 0; k < NB; k++) begin : g_step
                logic [Q:0] rem2;
                logic       ge;
                always_comb
                begin
                    rem2 = {rem_reg[ln][k], nq_reg[ln][k][NB-1]};
                    ge   = rem2 >= {1'b0, den_reg[ln][k]};
                    rem_next[ln][k+1] = ge ? Q'(rem2 - {1'b0, den_reg[ln][k]}) : rem2[Q-1:0];
                    nq_next[ln][k+1]  = {nq_reg[ln][k][NB-2:0], ge};
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NB-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg[0][0]  <= num0;
            nq_reg[1][0]  <= num1;
            den_reg[0][0] <= den0;
            den_reg[1][0] <= den1;
            rem_reg[0][0] <= '0;
            rem_reg[1][0] <= '0;
            side_reg[0]   <= side_in;
            for (int i = 1; i <= NB; i++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    nq_reg[j][i]  <= nq_next[j][i];
                    rem_reg[j][i] <= rem_next[j][i];
                    den_reg[j][i] <= den_reg[j][i-1];
                end
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[NB];
    assign quo0      = nq_reg[0][NB];
    assign quo1      = nq_reg[1][NB];
    assign side_out  = side_reg[NB];

endmodule

// ===== design/quadratic_real_roots.sv =====
// Top level of the pipelined real-root solver for a*t^2 + b*t + c.
//
//  channel   dir  tdata (low bit up)                 tuser
//  s_axis    in   coef_a, coef_b, coef_c             -
//  m_axis    out  root_low, root_high                status
//
// One coefficient set per cycle while the output is not stalled; the depth is
// set by the square-root stages (one bit each) and the divider stages (one
// quotient bit each). The default parameters give the Q16.16 format.
// Reset clears the valid bits only.
// A stall at the output freezes every stage together.
module quadratic_real_roots
    import qrr_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((3*WORD_BITS+7)/8)*8-1:0]      s_tdata,   // coef_a, coef_b, coef_c
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*WORD_BITS+7)/8)*8-1:0]      m_tdata,   // root_low, root_high
    output logic [1:0]                            m_tuser    // status
);

    `include "quadratic_real_roots_assert.svh"

    localparam int W     = WORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int R     = W + 1;
    localparam int DW    = 2 * R;
    localparam int Q     = W + 2;
    localparam int NB    = Q + F;
    localparam int OUT_W = ((2*W+7)/8)*8;
    localparam int FLW   = $bits(qrr_flags_t);
    localparam int SQ_SB = FLW + 3*W;
    localparam logic [NB-1:0] NEG_LIM = NB'(1) << (W-1);
    localparam logic [NB-1:0] POS_LIM = NEG_LIM - NB'(1);
    localparam logic [W-1:0]  W_MIN   = W'(1) << (W-1);
    localparam logic [W-1:0]  W_MAX   = W_MIN - W'(1);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // input stage
    logic            va_reg;
    qrr_flags_t      fa_reg;
    logic [W-1:0]    am_reg, bm_reg, cm_reg;
    logic [W-1:0]    a_in, b_in, c_in;

    assign a_in = s_tdata[W-1:0];
    assign b_in = s_tdata[2*W-1:W];
    assign c_in = s_tdata[3*W-1:2*W];

    // product stage
    logic            vb_reg;
    qrr_flags_t      fb_reg;
    logic [W-1:0]    amb_reg, bmb_reg, cmb_reg;
    logic [2*W-1:0]  b2_reg, ac_reg;
    logic            acpos_reg;

    // discriminant stage
    logic            vc_reg;
    qrr_flags_t      fc_reg;
    logic [W-1:0]    amc_reg, bmc_reg, cmc_reg;
    logic [DW-1:0]   d_reg;
    logic [DW-1:0]   b2_ext, ac4_ext;

    assign b2_ext  = DW'(b2_reg);
    assign ac4_ext = {ac_reg, 2'b00};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fa_reg.a_neg   <= a_in[W-1];
            fa_reg.b_neg   <= b_in[W-1];
            fa_reg.c_neg   <= c_in[W-1];
            fa_reg.no_real <= 1'b0;
            fa_reg.degen   <= 1'b0;
            am_reg <= a_in[W-1] ? (~a_in + W'(1)) : a_in;
            bm_reg <= b_in[W-1] ? (~b_in + W'(1)) : b_in;
            cm_reg <= c_in[W-1] ? (~c_in + W'(1)) : c_in;

            fb_reg    <= fa_reg;
            amb_reg   <= am_reg;
            bmb_reg   <= bm_reg;
            cmb_reg   <= cm_reg;
            b2_reg    <= (2*W)'(bm_reg) * (2*W)'(bm_reg);
            ac_reg    <= (2*W)'(am_reg) * (2*W)'(cm_reg);
            acpos_reg <= (am_reg != '0) && (cm_reg != '0) && (fa_reg.a_neg == fa_reg.c_neg);

            fc_reg.a_neg   <= fb_reg.a_neg;
            fc_reg.b_neg   <= fb_reg.b_neg;
            fc_reg.c_neg   <= fb_reg.c_neg;
            fc_reg.degen   <= fb_reg.degen;
            fc_reg.no_real <= acpos_reg && (b2_ext < ac4_ext);
            amc_reg        <= amb_reg;
            bmc_reg        <= bmb_reg;
            cmc_reg        <= cmb_reg;
            d_reg          <= acpos_reg ? (b2_ext - ac4_ext) : (b2_ext + ac4_ext);
        end
    end

    // square root
    logic             vs;
    logic [R-1:0]     root_s;
    logic [SQ_SB-1:0] side_s;
    qrr_flags_t       fs;
    logic [W-1:0]     ams, bms, cms;

    qrr_sqrt #(.R(R), .SB(SQ_SB)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vc_reg),
        .rad       (d_reg),
        .side_in   ({fc_reg, amc_reg, bmc_reg, cmc_reg}),
        .out_valid (vs),
        .root      (root_s),
        .side_out  (side_s)
    );

    assign {fs, ams, bms, cms} = side_s;

    // q stage
    logic            vq_reg;
    qrr_flags_t      fq_reg;
    logic [Q-1:0]    qm_reg;
    logic [W-1:0]    amq_reg, cmq_reg;
    logic [Q-1:0]    qm_sum;

    assign qm_sum = Q'(bms) + Q'(root_s);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fq_reg.a_neg   <= fs.a_neg;
            fq_reg.b_neg   <= fs.b_neg;
            fq_reg.c_neg   <= fs.c_neg;
            fq_reg.no_real <= fs.no_real;
            fq_reg.degen   <= (ams == '0) || (qm_sum == '0);
            qm_reg         <= qm_sum;
            amq_reg        <= ams;
            cmq_reg        <= cms;
        end
    end

    // divisions: |2q| / |2a| and |2c| / |2q|
    logic            vd;
    logic [NB-1:0]   quo0, quo1;
    logic [FLW-1:0]  side_d;
    qrr_flags_t      fd;

    qrr_div #(.NB(NB), .Q(Q), .SB(FLW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vq_reg),
        .num0      ({qm_reg, {F{1'b0}}}),
        .den0      (Q'({amq_reg, 1'b0})),
        .num1      (NB'({cmq_reg, 1'b0, {F{1'b0}}})),
        .den1      (qm_reg),
        .side_in   (fq_reg),
        .out_valid (vd),
        .quo0      (quo0),
        .quo1      (quo1),
        .side_out  (side_d)
    );

    assign fd = qrr_flags_t'(side_d);

    // clamp stage
    logic            vk_reg;
    qrr_flags_t      fk_reg;
    logic [W-1:0]    r1_reg, r2_reg;
    logic            sat_reg;
    logic            qn, neg1, neg2, ov1, ov2;
    logic [NB-1:0]   lim1, lim2, v1, v2;

    always_comb
    begin
        qn   = !fd.b_neg;
        neg1 = qn != fd.a_neg;
        neg2 = fd.c_neg != qn;
        lim1 = neg1 ? NEG_LIM : POS_LIM;
        lim2 = neg2 ? NEG_LIM : POS_LIM;
        ov1  = quo0 > lim1;
        ov2  = quo1 > lim2;
        v1   = ov1 ? lim1 : quo0;
        v2   = ov2 ? lim2 : quo1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fk_reg  <= fd;
            r1_reg  <= neg1 ? (~v1[W-1:0] + W'(1)) : v1[W-1:0];
            r2_reg  <= neg2 ? (~v2[W-1:0] + W'(1)) : v2[W-1:0];
            sat_reg <= ov1 || ov2;
        end
    end

    // sort and output
    logic [W-1:0]    lo_reg, hi_reg;
    logic [1:0]      st_reg;
    logic            vo_reg;
    logic            swap;

    assign swap = $signed(r1_reg) > $signed(r2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (fk_reg.no_real)
            begin
                st_reg <= ST_NOREAL;
                lo_reg <= '0;
                hi_reg <= '0;
            end
            else if (fk_reg.degen)
            begin
                st_reg <= ST_DEGEN;
                lo_reg <= '0;
                hi_reg <= '0;
            end
            else
            begin
                st_reg <= sat_reg ? ST_SAT : ST_OK;
                lo_reg <= swap ? r2_reg : r1_reg;
                hi_reg <= swap ? r1_reg : r2_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vq_reg <= 1'b0;
            vk_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vq_reg <= vs;
            vk_reg <= vd;
            vo_reg <= vk_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = OUT_W'({hi_reg, lo_reg});
    assign m_tuser  = st_reg;

    `QRR_ASSERT(a_zero_on_fail, clk, rst_n,
        m_tvalid && (m_tuser == ST_NOREAL || m_tuser == ST_DEGEN) |-> lo_reg == '0 && hi_reg == '0)
    `QRR_ASSERT(a_sorted, clk, rst_n, m_tvalid |-> $signed(lo_reg) <= $signed(hi_reg))
    `QRR_ASSERT(a_sat_at_rail, clk, rst_n,
        m_tvalid && m_tuser == ST_SAT |-> lo_reg == W_MIN || hi_reg == W_MAX)
    `QRR_ASSERT_NEXT(a_accept_enters, clk, rst_n, s_tvalid && s_tready, va_reg)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the fixed-point quadratic real-root solver.
module testbench;
    import qrr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] root_low;
        logic [31:0] root_high;
        logic [1:0]  status;
    } roots_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    roots_t expected_roots[$];
    int     mismatches = 0;
    int     cycles = 0;
    bit     idling_on = 1'b1;

    quadratic_real_roots u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] clamp_root(bit neg, logic [127:0] mag, inout bit sat);
        logic [127:0] lim;
        logic [127:0] v;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        v = mag;
        if (mag > lim)
        begin
            v = lim;
            sat = 1'b1;
        end
        return neg ? 32'd0 - v[31:0] : v[31:0];
    endfunction

    function automatic roots_t solve_quadratic(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        roots_t       r;
        bit           an, bn, cn, qn, sat;
        logic [127:0] am, bm, cm, b2, ac4, disc, root, cand, qm;
        logic [31:0]  r1, r2, t;
        an = a[31];
        bn = b[31];
        cn = c[31];
        am = {96'd0, an ? 32'd0 - a : a};
        bm = {96'd0, bn ? 32'd0 - b : b};
        cm = {96'd0, cn ? 32'd0 - c : c};
        r = '0;
        sat = 1'b0;
        b2 = bm * bm;
        ac4 = (am * cm) << 2;
        if (am != 0 && cm != 0 && an == cn)
        begin
            if (b2 < ac4)
            begin
                r.status = ST_NOREAL;
                return r;
            end
            disc = b2 - ac4;
        end
        else
            disc = b2 + ac4;
        root = '0;
        for (int i = 63; i >= 0; i--)
        begin
            cand = root | (128'd1 << i);
            if (cand * cand <= disc)
                root = cand;
        end
        qm = bm + root;
        if (am == 0 || qm == 0)
        begin
            r.status = ST_DEGEN;
            return r;
        end
        qn = !bn;
        r1 = clamp_root(qn != an, (qm << 16) / (am << 1), sat);
        r2 = clamp_root(cn != qn, (cm << 17) / qm, sat);
        if ($signed(r1) > $signed(r2))
        begin
            t = r1;
            r1 = r2;
            r2 = t;
        end
        r.root_low = r1;
        r.root_high = r2;
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        if (idling_on && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c, b, a};
        forever
        begin
            @(negedge clk);
            if (s_tready)
                break;
        end
        @(posedge clk);
        expected_roots.push_back(solve_quadratic(a, b, c));
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        m_tready <= idling_on ? ($urandom_range(99) >= 32) : 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        roots_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: %h %h", m_tdata, m_tuser);
            end
            else
            begin
                exp_r = expected_roots.pop_front();
                if (m_tdata[31:0] !== exp_r.root_low || m_tdata[63:32] !== exp_r.root_high
                    || m_tuser !== exp_r.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp low %h high %h st %0d, got low %h high %h st %0d",
                                 exp_r.root_low, exp_r.root_high, exp_r.status,
                                 m_tdata[31:0], m_tdata[63:32], m_tuser);
                end
            end
        end
    end

    task automatic test_directed();
        send_coefs(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000);  // t^2 - 1
        send_coefs(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);  // roots 1, 2
        send_coefs(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);  // negative discriminant
        send_coefs(32'h0000_0000, 32'h0001_0000, 32'h0001_0000);  // a zero
        send_coefs(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);  // q zero
        send_coefs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_coefs(32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001);  // saturation
        send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_coefs(32'h0000_0001, 32'h0000_0000, 32'h8000_0000);
        send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);  // double root
        send_coefs(32'hFFFF_0000, 32'h0000_0000, 32'h0004_0000);
        send_coefs(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
        send_coefs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0005);
    endtask

    task automatic test_random();
        logic [31:0] a, b, c;
        for (int n = 0; n < 500; n++)
        begin
            idling_on = !(n >= 200 && n < 300);
            case ($urandom_range(3))
                0:
                begin
                    a = $urandom;
                    b = $urandom;
                    c = $urandom;
                end
                1:
                begin
                    a = $signed($urandom_range(16'hFFFF)) - 32'sd32768 <<< 4;
                    b = $signed($urandom_range(24'hFFFFFF)) - 32'sd8388608;
                    c = $signed($urandom_range(24'hFFFFFF)) - 32'sd8388608;
                end
                2:
                begin
                    a = $signed($urandom_range(20'hFFFFF)) - 32'sd524288;
                    b = $urandom;
                    c = $signed($urandom_range(20'hFFFFF)) - 32'sd524288;
                end
                default:
                begin
                    a = ($urandom_range(3) == 0) ? 32'd0 : $urandom >> $urandom_range(31);
                    b = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
                    c = ($urandom_range(3) == 0) ? 32'd0 : $urandom >> $urandom_range(31);
                    if ($urandom_range(1))
                        a = -a;
                end
            endcase
            send_coefs(a, b, c);
        end
        idling_on = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        s_tvalid <= 1'b0;
        wait (expected_roots.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
